>>> rtl/nearest_marker_relabel_assert.svh
// Assertion macros shared by the checker of nearest_marker_relabel.
// Needs signals clk and rst in the scope where a macro is used.
`ifndef NEAREST_MARKER_RELABEL_ASSERT_SVH
`define NEAREST_MARKER_RELABEL_ASSERT_SVH

// Same-cycle implication.
`define NMR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NMR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/nmr_pkg.sv
// Package for nearest_marker_relabel: sizes, position type, and the
// command/status structs between nmr_ctrl and nmr_datapath. No dependencies.
`default_nettype none

package nmr_pkg;

  localparam int MAX_DETECTIONS = 64;
  localparam int NUM_LABELS     = 8;

  localparam int DET_W   = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;
  localparam int CNT_W   = $clog2(MAX_DETECTIONS + 1);
  localparam int LBL_W   = (NUM_LABELS > 1) ? $clog2(NUM_LABELS) : 1;
  localparam int COORD_W = 16;
  localparam int POS_W   = 2 * COORD_W;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int DIST_W  = SQ_W + 1;

  // x in the low half, y in the high half
  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    logic             load;       // store one detection from the ports
    logic             capture;    // latch click point for a seed
    logic             start;      // load target, rewind scan, clear best
    logic             seed;       // target is the click point
    logic             issue;      // read store at scan index, advance
    logic             fin;        // commit position, load result register
    logic             last;       // final result of this item
    logic             clr_count;  // empty the store after the frame's last label
    logic [LBL_W-1:0] lbl;        // label being worked on
  } ctrl_cmd_t;

  typedef struct packed {
    logic cnt_zero;    // store empty
    logic last_issue;  // scan index is at the last stored detection
    logic busy;        // distance pipe holds work
    logic out_free;    // result register can take a new result
  } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/nmr_ctrl.sv
// Controller of nearest_marker_relabel: input handshake, label sequencing,
// scan/drain/commit steps. Uses nmr_pkg command and status structs.
`default_nettype none

module nmr_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                action,
  input  wire logic [2:0]          label_index,
  input  wire logic                frame_end,
  input  wire nmr_pkg::dp_status_t status,
  output nmr_pkg::ctrl_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TGT   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  localparam logic [nmr_pkg::LBL_W-1:0] LAST_LBL = nmr_pkg::LBL_W'(nmr_pkg::NUM_LABELS - 1);

  logic [2:0]                state, state_next;
  logic [nmr_pkg::LBL_W-1:0] lbl, lbl_next;
  logic                      seed, seed_next;
  logic                      accept;
  logic                      lbl_ok;
  logic                      final_res;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign lbl_ok    = (32'(label_index) < nmr_pkg::NUM_LABELS);
  assign final_res = seed || (lbl == LAST_LBL);

  always_comb begin
    state_next    = state;
    lbl_next      = lbl;
    seed_next     = seed;
    cmd           = '0;
    cmd.lbl       = lbl;
    cmd.seed      = seed;
    cmd.last      = final_res;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (!action) begin
            cmd.load = 1'b1;
            if (frame_end) begin
              seed_next  = 1'b0;
              lbl_next   = '0;
              state_next = S_TGT;
            end
          end else if (lbl_ok) begin
            cmd.capture = 1'b1;
            seed_next   = 1'b1;
            lbl_next    = nmr_pkg::LBL_W'(label_index);
            state_next  = S_TGT;
          end
        end
      end
      S_TGT: begin
        cmd.start  = 1'b1;
        state_next = status.cnt_zero ? S_DRAIN : S_SCAN;
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (status.last_issue) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!status.busy) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.fin = 1'b1;
          if (seed) begin
            state_next = S_IDLE;
          end else if (lbl == LAST_LBL) begin
            cmd.clr_count = 1'b1;
            state_next    = S_IDLE;
          end else begin
            lbl_next   = lbl + nmr_pkg::LBL_W'(1);
            state_next = S_TGT;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      lbl   <= '0;
      seed  <= 1'b0;
    end else begin
      state <= state_next;
      lbl   <= lbl_next;
      seed  <= seed_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/nmr_datapath.sv
// Datapath of nearest_marker_relabel: detection store, label positions,
// pipelined squared-distance unit, best tracker, result register. Uses nmr_pkg.
`default_nettype none

module nmr_datapath (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire nmr_pkg::ctrl_cmd_t    cmd,
  output nmr_pkg::dp_status_t        status,
  input  wire logic [15:0]           point_x,
  input  wire logic [15:0]           point_y,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [2:0]                 label_out,
  output logic [15:0]                pos_x,
  output logic [15:0]                pos_y,
  output logic                       matched,
  output logic                       last_out
);

  localparam int CW = nmr_pkg::COORD_W;

  // detection store, contents undefined until written
  nmr_pkg::pos_t             store [nmr_pkg::MAX_DETECTIONS];
  logic [nmr_pkg::CNT_W-1:0] cnt;
  logic [nmr_pkg::DET_W-1:0] rd_idx;
  nmr_pkg::pos_t             rd_data;

  nmr_pkg::pos_t             lpos [nmr_pkg::NUM_LABELS];
  nmr_pkg::pos_t             seed_pt;
  nmr_pkg::pos_t             tgt;
  nmr_pkg::pos_t             cur_pos;

  logic                      v1, v2, v3;
  nmr_pkg::pos_t             pos2, pos3;
  logic [CW-1:0]             dx, dy;
  logic [CW-1:0]             dx_c, dy_c;
  logic [nmr_pkg::SQ_W-1:0]  sqx, sqy;
  logic [nmr_pkg::DIST_W-1:0] sq_sum;

  logic                      best_valid;
  logic [nmr_pkg::DIST_W-1:0] best_d;
  nmr_pkg::pos_t             best_pos;

  logic                      store_wr;

  assign store_wr = cmd.load && (32'(cnt) < nmr_pkg::MAX_DETECTIONS);
  assign cur_pos  = lpos[cmd.lbl];

  assign status.cnt_zero   = (cnt == '0);
  assign status.last_issue = ((32'(rd_idx) + 32'd1) == 32'(cnt));
  assign status.busy       = v1 || v2 || v3;
  assign status.out_free   = !out_valid || out_ready;

  // store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (store_wr) begin
      store[cnt[nmr_pkg::DET_W-1:0]] <= {point_y, point_x};
    end
    rd_data <= store[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.clr_count) begin
      cnt <= '0;
    end else if (store_wr) begin
      cnt <= cnt + nmr_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rd_idx <= '0;
    end else if (cmd.issue) begin
      rd_idx <= rd_idx + nmr_pkg::DET_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      seed_pt <= {point_y, point_x};
    end
    if (cmd.start) begin
      tgt <= cmd.seed ? seed_pt : cur_pos;
    end
  end

  // distance pipe: abs diff -> squares -> sum and compare
  assign dx_c = (rd_data[CW-1:0] >= tgt[CW-1:0]) ? rd_data[CW-1:0] - tgt[CW-1:0]
                                                  : tgt[CW-1:0] - rd_data[CW-1:0];
  assign dy_c = (rd_data[2*CW-1:CW] >= tgt[2*CW-1:CW])
              ? rd_data[2*CW-1:CW] - tgt[2*CW-1:CW]
              : tgt[2*CW-1:CW] - rd_data[2*CW-1:CW];
  assign sq_sum = {1'b0, sqx} + {1'b0, sqy};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    dx   <= dx_c;
    dy   <= dy_c;
    pos2 <= rd_data;
    sqx  <= nmr_pkg::SQ_W'(dx) * nmr_pkg::SQ_W'(dx);
    sqy  <= nmr_pkg::SQ_W'(dy) * nmr_pkg::SQ_W'(dy);
    pos3 <= pos2;
  end

  // strict less-than keeps the earliest detection on ties
  always_ff @(posedge clk) begin
    if (rst) begin
      best_valid <= 1'b0;
    end else if (cmd.start) begin
      best_valid <= 1'b0;
    end else if (v3 && (!best_valid || (sq_sum < best_d))) begin
      best_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (v3 && (!best_valid || (sq_sum < best_d))) begin
      best_d   <= sq_sum;
      best_pos <= pos3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < nmr_pkg::NUM_LABELS; i++) begin
        lpos[i] <= '0;
      end
    end else if (cmd.fin && best_valid) begin
      lpos[cmd.lbl] <= best_pos;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      label_out <= 3'(cmd.lbl);
      pos_x     <= best_valid ? best_pos[CW-1:0] : cur_pos[CW-1:0];
      pos_y     <= best_valid ? best_pos[2*CW-1:CW] : cur_pos[2*CW-1:CW];
      matched   <= best_valid;
      last_out  <= cmd.last;
    end
  end

endmodule

`default_nettype wire

>>> rtl/nearest_marker_relabel.sv
// A load without frame_end leaves the block idle. Each label or seed match runs the
// one-read-a-cycle scan of the detection store (skipped when it holds no detections),
// feeding the distance pipe. A frame end runs one match per label, and a match waits
// to commit while a result is not taken; one item at a time.
// Reset (rst, synchronous): store emptied (count 0), all label positions 0, no result
// pending. Store contents are not cleared and no clearing pass runs.
//
// Top level of nearest_marker_relabel. Depends on nmr_pkg, nmr_ctrl, nmr_datapath.
`default_nettype none

module nearest_marker_relabel (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel: one transfer per detection or seed click
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        action,
  input  wire logic [15:0] point_x,
  input  wire logic [15:0] point_y,
  input  wire logic [2:0]  label_index,
  input  wire logic        frame_end,
  // output channel: one transfer per label result
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       label_out,
  output logic [15:0]      pos_x,
  output logic [15:0]      pos_y,
  output logic             matched,
  output logic             last_out
);

  nmr_pkg::ctrl_cmd_t  cmd;
  nmr_pkg::dp_status_t status;

  // Controller: accepts transfers only while idle. A load is stored when there is room;
  // frame_end (or a seed with a valid label) starts the match sequence.
  nmr_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .label_index (label_index),
    .frame_end   (frame_end),
    .status      (status),
    .cmd         (cmd)
  );

  // Datapath: per target, streams the stored detections through the distance pipe,
  // keeps the earliest nearest, then commits the position and loads the result
  // register. The result register frees the controller to scan the next label while
  // the previous result waits for the downstream side.
  nmr_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .point_x   (point_x),
    .point_y   (point_y),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .label_out (label_out),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .matched   (matched),
    .last_out  (last_out)
  );

endmodule

`default_nettype wire

>>> rtl/nmr_checker.sv
// Port-level checker for nearest_marker_relabel, bound to the top level.
// Depends on nmr_pkg and nearest_marker_relabel_assert.svh.
`default_nettype none

`include "nearest_marker_relabel_assert.svh"

module nmr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        action,
  input wire logic [2:0]  label_index,
  input wire logic        frame_end,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  label_out,
  input wire logic [15:0] pos_x,
  input wire logic [15:0] pos_y,
  input wire logic        matched,
  input wire logic        last_out
);

  logic starts_work;
  logic stalled;

  assign starts_work = in_valid && in_ready &&
                       ((!action && frame_end) ||
                        (action && (32'(label_index) < nmr_pkg::NUM_LABELS)));
  assign stalled     = out_valid && !out_ready;

  // stalled result holds
  `NMR_ASSERT_NEXT(a_out_hold, stalled,
    out_valid && $stable(pos_x) && $stable(pos_y) && $stable(label_out) &&
    $stable(matched) && $stable(last_out), "result changed while stalled")

  // highest label always closes its match
  `NMR_ASSERT_NOW(a_top_label_last, out_valid && !last_out,
    label_out != 3'(nmr_pkg::NUM_LABELS - 1), "top label result without last_out")

  // mid-match result means no new input is taken
  `NMR_ASSERT_NOW(a_busy_mid_match, out_valid && !last_out,
    !in_ready, "input ready during a match")

  // a match or seed occupies the block in the next cycle
  `NMR_ASSERT_NEXT(a_busy_after_start, starts_work,
    !in_ready, "input ready right after a match started")

endmodule

bind nearest_marker_relabel nmr_checker u_nmr_checker (.*);

`default_nettype wire
